// ===== src/modbus_read_request_framer_core_macros.svh =====
// Assertion macros used by the checker file mrrf_checker.sv.
`ifndef MODBUS_READ_REQUEST_FRAMER_CORE_MACROS_SVH
`define MODBUS_READ_REQUEST_FRAMER_CORE_MACROS_SVH

// Next-cycle implication, ignored while reset is held.
`define MRRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrrf assertion failed");

// Next-cycle implication that is checked during reset as well.
`define MRRF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mrrf assertion failed");

`endif

// ===== src/mrrf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mrrf_pkg;

  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam int          HDR_BYTES         = 6;
  localparam int          FRAME_BYTES       = 8;
  localparam int          IDX_W             = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(FRAME_BYTES - 1);

  typedef struct packed {
    logic [15:0] register_count;
    logic [15:0] start_register;
    logic [7:0]  slave_address;
  } req_t;

  // Header byte k of the frame, k in 0..5.
  function automatic logic [7:0] hdr_byte(input req_t req, input logic [IDX_W-1:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = req.slave_address;
      3'd1:    b = FUNC_READ_HOLDING;
      3'd2:    b = req.start_register[15:8];
      3'd3:    b = req.start_register[7:0];
      3'd4:    b = req.register_count[15:8];
      3'd5:    b = req.register_count[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // One byte of CRC-16/Modbus, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/mrrf_crc_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One stage per header byte; the request rides along with its running CRC.
module mrrf_crc_pipe (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire mrrf_pkg::req_t  in_req,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output mrrf_pkg::req_t       out_req,
  output logic [15:0]          out_crc
);

  localparam int N = mrrf_pkg::HDR_BYTES;

  logic           vld_r   [N];
  logic           vld_nxt [N];
  mrrf_pkg::req_t req_r   [N];
  logic [15:0]    crc_r   [N];
  logic           adv     [N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic           src_vld;
      mrrf_pkg::req_t src_req;
      logic [15:0]    src_crc;

      if (k == 0) begin : g_first
        assign src_vld = in_valid;
        assign src_req = in_req;
        assign src_crc = mrrf_pkg::CRC_INIT;
      end else begin : g_rest
        assign src_vld = vld_r[k-1];
        assign src_req = req_r[k-1];
        assign src_crc = crc_r[k-1];
      end

      // Stage moves when empty or when its downstream takes its item.
      if (k == N - 1) begin : g_adv_last
        assign adv[k] = !vld_r[k] || out_ready;
      end else begin : g_adv_mid
        assign adv[k] = !vld_r[k] || adv[k+1];
      end

      always_comb begin
        vld_nxt[k] = adv[k] ? src_vld : vld_r[k];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else begin
          vld_r[k] <= vld_nxt[k];
        end
      end

      always_ff @(posedge clk) begin
        if (adv[k] && src_vld) begin
          req_r[k] <= src_req;
          crc_r[k] <= mrrf_pkg::crc_byte(src_crc,
                        mrrf_pkg::hdr_byte(src_req, mrrf_pkg::IDX_W'(k)));
        end
      end
    end
  endgenerate

  assign in_ready  = adv[0];
  assign out_valid = vld_r[N-1];
  assign out_req   = req_r[N-1];
  assign out_crc   = crc_r[N-1];

endmodule
`default_nettype wire

// ===== src/mrrf_serializer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Holds one finished frame and sends it a byte at a time.
module mrrf_serializer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire mrrf_pkg::req_t  in_req,
  input  wire logic [15:0]     in_crc,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast
);

  logic [7:0]                frame_r [mrrf_pkg::FRAME_BYTES];
  logic [mrrf_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                      vld_r, vld_nxt;
  logic                      load, take, at_last;

  assign at_last  = (idx_r == mrrf_pkg::LAST_IDX);
  assign take     = vld_r && out_tready;
  // Next frame loads as the final byte of the current one leaves.
  assign in_ready = !vld_r || (out_tready && at_last);
  assign load     = in_valid && in_ready;

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      idx_nxt = '0;
      vld_nxt = 1'b1;
    end else if (take) begin
      idx_nxt = idx_r + 1'b1;
      if (at_last) vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < mrrf_pkg::HDR_BYTES; i++) begin
        frame_r[i] <= mrrf_pkg::hdr_byte(in_req, mrrf_pkg::IDX_W'(i));
      end
      frame_r[mrrf_pkg::HDR_BYTES]     <= in_crc[7:0];
      frame_r[mrrf_pkg::HDR_BYTES + 1] <= in_crc[15:8];
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = frame_r[idx_r];
  assign out_tlast  = at_last;

endmodule
`default_nettype wire

// ===== src/modbus_read_request_framer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Modbus RTU read-holding-registers request framer. Each request on the in_ stream
// yields the 8-byte frame on the out_ stream: address, 0x03, start hi/lo, count hi/lo,
// CRC low, CRC high (CRC-16/Modbus), with out_tlast on the CRC high byte. The CRC is
// computed in a six-stage pipeline, one header byte per stage, then the frame is loaded
// into the serializer, which sends it from its first byte. The one-byte output port
// limits the request rate: a frame leaves a byte at a time, frames leaving back to back
// with no gap between them. Requests queue in the pipeline while a frame is still
// being sent. Nothing is kept between requests.
module modbus_read_request_framer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // slave_address[7:0], start_register[23:8],
                                       // register_count[39:24]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // tx_byte[7:0]
  output logic             out_tlast   // last_byte
);

  mrrf_pkg::req_t req;
  mrrf_pkg::req_t pipe_req;
  logic [15:0]    pipe_crc;
  logic           pipe_valid, pipe_ready;

  assign req.slave_address  = in_tdata[7:0];
  assign req.start_register = in_tdata[23:8];
  assign req.register_count = in_tdata[39:24];

  mrrf_crc_pipe u_crc_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (req),
    .out_valid (pipe_valid),
    .out_ready (pipe_ready),
    .out_req   (pipe_req),
    .out_crc   (pipe_crc)
  );

  mrrf_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pipe_valid),
    .in_ready   (pipe_ready),
    .in_req     (pipe_req),
    .in_crc     (pipe_crc),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== src/mrrf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_read_request_framer_core_macros.svh"
module mrrf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast
);

  // Nothing comes out right after reset.
  `MRRF_ASSERT_NEXT_ALWAYS(a_idle_after_rst, clk, !rst_n, !out_tvalid)

  // A frame never breaks off before its last byte.
  `MRRF_ASSERT_NEXT(a_frame_whole, clk, rst_n,
                    out_tvalid && out_tready && !out_tlast, out_tvalid)

  // A stalled byte holds.
  `MRRF_ASSERT_NEXT(a_out_hold, clk, rst_n,
                    out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // A taken last byte is never followed directly by another last.
  `MRRF_ASSERT_NEXT(a_no_double_last, clk, rst_n,
                    out_tvalid && out_tready && out_tlast, !out_tlast)

endmodule

bind modbus_read_request_framer_core mrrf_checker u_mrrf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
